>>> rtl/arpc_pkg.sv
// Shared constants, codes and control types for the ARP cache table.
package arpc_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int OP_W    = 2;
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int TTL_W   = 8;
	localparam int STAT_W  = 3;
	localparam int EIDX_W  = 3;

	localparam logic [OP_W-1:0] OP_LEARN  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd0;
	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_HIT       = 3'd3;
	localparam logic [STAT_W-1:0] ST_MISS      = 3'd4;
	localparam logic [STAT_W-1:0] ST_TICK_DONE = 3'd5;

	localparam logic [TTL_W-1:0] TTL_RELOAD_RST = 8'd8;
	localparam logic [MAC_W-1:0] MAC_BROADCAST  = {MAC_W{1'b1}};

	typedef struct packed {
		logic cap;
		logic exec;
	} arpc_cmd_t;

	typedef struct packed {
		logic has_result;
	} arpc_stat_t;

endpackage

>>> rtl/arpc_ifs.sv
// Handshake channel interfaces for requests, responses and configuration.
interface arpc_req_if;
	import arpc_pkg::*;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [IP_W-1:0]  ip_addr;
	logic [IP_W-1:0]  next_hop_ip;
	logic [MAC_W-1:0] mac_addr;
	modport source (output valid, op, ip_addr, next_hop_ip, mac_addr, input ready);
	modport sink (input valid, op, ip_addr, next_hop_ip, mac_addr, output ready);
endinterface

interface arpc_rsp_if;
	import arpc_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [MAC_W-1:0]  dest_mac;
	logic [EIDX_W-1:0] entry_index;
	modport source (output valid, status, dest_mac, entry_index, input ready);
	modport sink (input valid, status, dest_mac, entry_index, output ready);
endinterface

interface arpc_cfg_if;
	import arpc_pkg::*;
	logic             valid;
	logic             ready;
	logic [TTL_W-1:0] ttl_reload;
	modport source (output valid, ttl_reload, input ready);
	modport sink (input valid, ttl_reload, output ready);
endinterface

>>> rtl/arpc_dp.sv
// Datapath: entry table, parallel match, free-slot search and result register.
module arpc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  arpc_pkg::arpc_cmd_t              cmd,
	output arpc_pkg::arpc_stat_t             stat,
	input  logic                             cfg_we,
	input  logic [arpc_pkg::TTL_W-1:0]       cfg_ttl,
	input  logic [arpc_pkg::OP_W-1:0]        in_op,
	input  logic [arpc_pkg::IP_W-1:0]        in_ip,
	input  logic [arpc_pkg::IP_W-1:0]        in_next_hop,
	input  logic [arpc_pkg::MAC_W-1:0]       in_mac,
	output logic [arpc_pkg::STAT_W-1:0]      out_status,
	output logic [arpc_pkg::MAC_W-1:0]       out_mac,
	output logic [arpc_pkg::EIDX_W-1:0]      out_index
);
	import arpc_pkg::*;

	logic [IP_W-1:0]   ip_q  [TABLE_ENTRIES];
	logic [MAC_W-1:0]  mac_q [TABLE_ENTRIES];
	logic [TTL_W-1:0]  ttl_q [TABLE_ENTRIES];
	logic [TTL_W-1:0]  ttl_reload_q;

	logic [OP_W-1:0]   op_s1;
	logic [IP_W-1:0]   key_s1;
	logic [MAC_W-1:0]  mac_s1;

	logic [STAT_W-1:0] status_q;
	logic [MAC_W-1:0]  dest_mac_q;
	logic [EIDX_W-1:0] index_q;

	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              any_free;
	logic [IDX_W-1:0]  free_idx;

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		any_free = 1'b0;
		free_idx = '0;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if (!hit && ip_q[k] == key_s1) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(k);
			end
			if (!any_free && ttl_q[k] == '0) begin
				any_free = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	assign stat.has_result = (op_s1 == OP_LEARN) || (op_s1 == OP_LOOKUP) || (op_s1 == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_reload_q <= TTL_RELOAD_RST;
		end else if (cfg_we) begin
			ttl_reload_q <= cfg_ttl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_s1  <= in_op;
			key_s1 <= (in_op == OP_LOOKUP && in_next_hop != '0) ? in_next_hop : in_ip;
			mac_s1 <= in_mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				ip_q[k]  <= '0;
				mac_q[k] <= '0;
				ttl_q[k] <= '0;
			end
		end else if (cmd.exec) begin
			unique case (op_s1)
				OP_LEARN: begin
					if (hit) begin
						mac_q[hit_idx] <= mac_s1;
						ttl_q[hit_idx] <= ttl_reload_q;
					end else if (any_free) begin
						ip_q[free_idx]  <= key_s1;
						mac_q[free_idx] <= mac_s1;
						ttl_q[free_idx] <= ttl_reload_q;
					end
				end
				OP_TICK: begin
					for (int k = 0; k < TABLE_ENTRIES; k++) begin
						if (ttl_q[k] != '0) begin
							ttl_q[k] <= ttl_q[k] - TTL_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			unique case (op_s1)
				OP_LEARN: begin
					dest_mac_q <= '0;
					if (hit) begin
						status_q <= ST_REFRESHED;
						index_q  <= EIDX_W'(hit_idx);
					end else if (any_free) begin
						status_q <= ST_INSERTED;
						index_q  <= EIDX_W'(free_idx);
					end else begin
						status_q <= ST_FULL;
						index_q  <= '0;
					end
				end
				OP_LOOKUP: begin
					if (hit) begin
						status_q   <= ST_HIT;
						dest_mac_q <= mac_q[hit_idx];
						index_q    <= EIDX_W'(hit_idx);
					end else begin
						status_q   <= ST_MISS;
						dest_mac_q <= MAC_BROADCAST;
						index_q    <= '0;
					end
				end
				OP_TICK: begin
					status_q   <= ST_TICK_DONE;
					dest_mac_q <= '0;
					index_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_status = status_q;
	assign out_mac    = dest_mac_q;
	assign out_index  = index_q;

endmodule

>>> rtl/arpc_ctrl.sv
// Controller: sequences capture and execute, owns the response valid flag.
module arpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output arpc_pkg::arpc_cmd_t  cmd,
	input  arpc_pkg::arpc_stat_t stat
);
	import arpc_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.cap   = in_valid && in_ready;
	assign cmd.exec  = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (cmd.cap) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.exec) begin
						out_valid_q <= stat.has_result;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/arp_cache_table_top.sv
// Top level of the ARP cache table: controller, datapath and channel hookup.
//
//   channel | role   | payload
//   --------+--------+-----------------------------------------------
//   req     | sink   | op, ip_addr, next_hop_ip, mac_addr
//   rsp     | source | status, dest_mac, entry_index
//   cfg     | sink   | ttl_reload (always ready)
//
// Capture registers each request and selects the key; execute compares all slots
// in parallel and updates the table and result register.
// A result waits in its register while the next request is taken in.
// Reset clears every slot to IP 0, MAC 0, TTL 0 and loads ttl_reload with 8.
// A held result stalls only the execute step of the following item.
module arp_cache_table_top (
	input  logic        clk,
	input  logic        arst_n,
	arpc_req_if.sink    req,
	arpc_rsp_if.source  rsp,
	arpc_cfg_if.sink    cfg
);
	import arpc_pkg::*;

	arpc_cmd_t  cmd;
	arpc_stat_t stat;

	assign cfg.ready = 1'b1;

	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	arpc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_ttl     (cfg.ttl_reload),
		.in_op       (req.op),
		.in_ip       (req.ip_addr),
		.in_next_hop (req.next_hop_ip),
		.in_mac      (req.mac_addr),
		.out_status  (rsp.status),
		.out_mac     (rsp.dest_mac),
		.out_index   (rsp.entry_index)
	);

endmodule
